[hdl/assert_macros.svh]
// Assertion macros shared by the frame checker RTL.
// Included by modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

[hdl/fsfc_pkg.sv]
// Shared types, constants and the CRC-8 step function of the flow frame checker.
// No dependencies; imported by the top level, fsfc_front, fsfc_queue and fsfc_back.
`default_nettype none

package fsfc_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 16;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam logic signed [16:0] FLOW_FAIL = -17'sd1;

  // Byte addresses of the configuration registers.
  localparam logic [2:0] REG_FLOW_OFFSET = 3'd0;
  localparam logic [2:0] REG_FLOW_SCALE  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_CRC = 2'd1,
    ST_BUS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    POS_IDLE,
    POS_LOW,
    POS_CHECK
  } pos_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

  // One finished frame handed from the front end to the converter.
  typedef struct packed {
    status_t            status;
    logic signed [16:0] diff;
  } job_t;

  // One byte through the CRC-8, MSB first.
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/fsfc_chan_if.sv]
// Valid/ready channel interfaces for the received bytes and the frame results.
// No dependencies.
`default_nettype none

interface fsfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;
  logic       bus_fault;

  modport source(output valid, rx_byte, frame_start, bus_fault, input ready);
  modport sink(input valid, rx_byte, frame_start, bus_fault, output ready);
endinterface

interface fsfc_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] flow_value;
  logic [1:0]         frame_status;

  modport source(output valid, flow_value, frame_status, input ready);
  modport sink(input valid, flow_value, frame_status, output ready);
endinterface

`default_nettype wire

[hdl/flow_sensor_frame_check_convert.sv]
// Flow-sensor frame checker and converter, top level; uses fsfc_pkg, the channel
// interfaces, fsfc_front, fsfc_queue and fsfc_back.
// A result passes through the frame queue and, for a good frame, the divider before it is valid.
// Throughput: one byte per cycle while the frame queue has room; the converter takes a
// new frame only after its 16-step bit-serial divider and the output hand-off finish.
// Reset (synchronous, rst_n low): frame state, queue and converter go idle, offset 0, scale 1.
`default_nettype none

module flow_sensor_frame_check_convert #(
  parameter int QUEUE_DEPTH = fsfc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  fsfc_in_if.sink     in_ch,
  fsfc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fsfc_pkg::*;

  // Register select is address bit 2: offset at 0x0, scale at 0x4.
  localparam logic REG_OFFSET = REG_FLOW_OFFSET[2];
  localparam logic REG_SCALE  = REG_FLOW_SCALE[2];

  logic [15:0] flow_offset_r;
  logic [15:0] flow_scale_r;
  logic        cfg_wr;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  // The configuration port never waits. A write lands on the access cycle of the
  // transaction; software must write only while no frame is in flight (the block does
  // not enforce this), so the front end and converter can read the registers directly.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_offset_r <= 16'h0000;
      flow_scale_r  <= 16'h0001;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_OFFSET: flow_offset_r <= pwdata[15:0];
        REG_SCALE:  flow_scale_r  <= pwdata[15:0];
        default:    flow_offset_r <= flow_offset_r;
      endcase
    end
  end

  // Reads of a misaligned address return zero.
  always_comb begin
    if (paddr[1:0] != 2'b00) begin
      prdata = 32'h0000_0000;
    end else if (paddr[2] == REG_SCALE) begin
      prdata = {16'h0000, flow_scale_r};
    end else begin
      prdata = {16'h0000, flow_offset_r};
    end
  end

  // The front end takes one byte per transaction, folds the data bytes into the CRC
  // and the raw value, and on the checksum byte pushes the frame status together with
  // the offset-corrected raw value. It stalls the input only when the queue is full.
  fsfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .flow_offset(flow_offset_r),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // The queue lets the front end keep taking bytes while the converter divides or
  // waits on a result the output side has not taken yet.
  fsfc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .pop_job (pop_job),
    .empty   (q_empty)
  );

  // The converter divides good frames by the scale with truncation toward zero
  // and registers every result for the output transaction.
  fsfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_job   (pop_job),
    .empty     (q_empty),
    .pop       (pop),
    .flow_scale(flow_scale_r),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[hdl/fsfc_front.sv]
// Front end: takes bytes, tracks the frame position, runs the CRC and classifies frames.
// Depends on fsfc_pkg, fsfc_in_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fsfc_front (
  input  logic          clk,
  input  logic          rst_n,
  fsfc_in_if.sink       in_ch,
  input  logic [15:0]   flow_offset,
  input  logic          q_full,
  output logic          push,
  output fsfc_pkg::job_t push_job
);
  import fsfc_pkg::*;

  pos_t       pos_r, pos_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [15:0] raw_r, raw_nxt;
  logic       fault_r, fault_nxt;
  logic       accept;
  logic       fault_all;
  logic [7:0] crc_upd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_IDLE;
      crc_r   <= 8'h00;
      raw_r   <= 16'h0000;
      fault_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      raw_r   <= raw_nxt;
      fault_r <= fault_nxt;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    raw_nxt   = raw_r;
    fault_nxt = fault_r;
    push      = 1'b0;

    crc_upd   = crc_feed(in_ch.frame_start ? 8'h00 : crc_r, in_ch.rx_byte);
    fault_all = fault_r | in_ch.bus_fault;

    // Bus errors outrank a checksum mismatch.
    if (fault_all) begin
      push_job.status = ST_BUS;
    end else if (crc_r != in_ch.rx_byte) begin
      push_job.status = ST_CRC;
    end else begin
      push_job.status = ST_OK;
    end
    push_job.diff = $signed({1'b0, raw_r} - {1'b0, flow_offset});

    if (accept) begin
      if (in_ch.frame_start) begin
        // A start mark always opens a new frame, dropping any partial one.
        crc_nxt   = crc_upd;
        raw_nxt   = {in_ch.rx_byte, 8'h00};
        fault_nxt = in_ch.bus_fault;
        pos_nxt   = POS_LOW;
      end else begin
        unique case (pos_r)
          POS_IDLE: begin
            pos_nxt = POS_IDLE;
          end
          POS_LOW: begin
            crc_nxt   = crc_upd;
            raw_nxt   = {raw_r[15:8], in_ch.rx_byte};
            fault_nxt = fault_all;
            pos_nxt   = POS_CHECK;
          end
          POS_CHECK: begin
            fault_nxt = fault_all;
            push      = 1'b1;
            pos_nxt   = POS_IDLE;
          end
          default: begin
            pos_nxt = POS_IDLE;
          end
        endcase
      end
    end
  end

  `ASSERT_CLK(a_push_on_check, push |-> (pos_r == POS_CHECK && !in_ch.frame_start), "frame pushed outside the checksum byte")
  `ASSERT_CLK(a_start_opens, (accept && in_ch.frame_start) |=> (pos_r == POS_LOW), "start byte did not open a frame")

endmodule

`default_nettype wire

[hdl/fsfc_queue.sv]
// Short FIFO of classified frames between the front end and the converter.
// Depends on fsfc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fsfc_queue #(
  parameter int DEPTH = fsfc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fsfc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output fsfc_pkg::job_t pop_job,
  output logic           empty
);
  import fsfc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  `ASSERT_NEVER(a_no_overflow, push && full, "push into a full frame queue")
  `ASSERT_NEVER(a_no_underflow, pop && empty, "pop from an empty frame queue")

endmodule

`default_nettype wire

[hdl/fsfc_back.sv]
// Converter: pops classified frames, divides by the scale one quotient bit per cycle
// and holds the result for the output channel. Depends on fsfc_pkg, fsfc_out_if, macros.
`default_nettype none
`include "assert_macros.svh"

module fsfc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  fsfc_pkg::job_t pop_job,
  input  logic           empty,
  output logic           pop,
  input  logic [15:0]    flow_scale,
  fsfc_out_if.source     out_ch
);
  import fsfc_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  back_state_t        state_r, state_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [15:0]        quo_r, quo_nxt;
  logic [15:0]        dvs_r, dvs_nxt;
  logic               neg_r, neg_nxt;
  logic signed [16:0] flow_r, flow_nxt;
  status_t            status_r, status_nxt;

  logic [17:0] trial;
  logic        fits;
  logic [15:0] rem_step;
  logic [15:0] quo_step;
  logic [16:0] mag;
  logic [16:0] q_vec;

  assign out_ch.valid        = (state_r == BK_HOLD);
  assign out_ch.flow_value   = flow_r;
  assign out_ch.frame_status = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dvs_r    <= dvs_nxt;
    neg_r    <= neg_nxt;
    flow_r   <= flow_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    neg_nxt    = neg_r;
    flow_nxt   = flow_r;
    status_nxt = status_r;
    pop        = 1'b0;

    // Restoring division step: the dividend shifts out of quo_r, quotient bits shift in.
    trial    = {1'b0, rem_r, quo_r[15]} - {2'b00, dvs_r};
    fits     = !trial[17];
    rem_step = fits ? trial[15:0] : {rem_r[14:0], quo_r[15]};
    quo_step = {quo_r[14:0], fits};
    q_vec    = neg_r ? (17'd0 - {1'b0, quo_step}) : {1'b0, quo_step};

    mag = pop_job.diff[16] ? (17'd0 - pop_job.diff) : pop_job.diff;

    unique case (state_r)
      BK_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          status_nxt = pop_job.status;
          if (pop_job.status != ST_OK) begin
            flow_nxt  = FLOW_FAIL;
            state_nxt = BK_HOLD;
          end else begin
            quo_nxt   = mag[15:0];
            rem_nxt   = 16'h0000;
            dvs_nxt   = (flow_scale == 16'h0000) ? 16'h0001 : flow_scale;
            neg_nxt   = pop_job.diff[16];
            cnt_nxt   = '0;
            state_nxt = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          flow_nxt  = $signed(q_vec);
          state_nxt = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_ch.ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_fail_flow, (out_ch.valid && status_r != ST_OK) |-> (flow_r == FLOW_FAIL), "failed frame without flow of -1")
  `ASSERT_CLK(a_div_ends, (state_r == BK_DIV && cnt_r == LAST_STEP) |=> (state_r == BK_HOLD), "division did not end on its last step")

endmodule

`default_nettype wire
